// ----- rtl/piecewise_linear_lut_convert_core_defines.svh -----
// Assertion macros used by the piecewise linear converter core.
`ifndef PIECEWISE_LINEAR_LUT_CONVERT_CORE_DEFINES_SVH
`define PIECEWISE_LINEAR_LUT_CONVERT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLCVT_ASSERT_SAME(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLCVT_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

// ----- rtl/plcvt_pkg.sv -----
// Shared constants, types and the microcode program of the piecewise linear converter.
package plcvt_pkg;

	localparam int MAX_POINTS_DEF = 16;
	localparam int VALUE_BITS     = 16;
	localparam int FRAC_BITS      = 8;
	localparam int FIELD_BITS     = 16;
	localparam int INDEX_BITS     = 4;
	localparam int COUNT_BITS     = 5;
	localparam int STATUS_BITS    = 3;
	localparam int PC_BITS        = 4;
	localparam int DIV_BITS       = FIELD_BITS + FRAC_BITS;
	localparam int PROD_BITS      = FIELD_BITS + DIV_BITS;
	localparam int DELTA_BITS     = VALUE_BITS + 1;
	localparam int SUM_BITS       = VALUE_BITS + 2;
	localparam logic [63:0] MAX_VALUE64 = (64'd1 << VALUE_BITS) - 64'd1;

	// Result status codes.
	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK         = 3'd0,
		ST_PASS       = 3'd1,
		ST_CLAMP      = 3'd2,
		ST_SAT        = 3'd3,
		ST_ZERO_WIDTH = 3'd4
	} status_t;

	// Datapath operations, one per control word.
	typedef enum logic [3:0] {
		OP_IDLE,
		OP_NOP,
		OP_RDX,
		OP_INCPOS,
		OP_SEL,
		OP_RDLO,
		OP_RDHI,
		OP_DIFF,
		OP_DIVINIT,
		OP_DIVSTEP,
		OP_MUL,
		OP_DELTA,
		OP_FINISH,
		OP_PASS,
		OP_ZW
	} op_t;

	// Jump conditions tested by the sequencer.
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_CONV,
		C_FEW,
		C_FOUND,
		C_NOT_LAST,
		C_ZW,
		C_DIV_MORE
	} cond_t;

	typedef struct packed {
		op_t                op;
		cond_t              cond;
		logic [PC_BITS-1:0] target;
	} ucode_t;

	// Condition flags from the datapath to the sequencer.
	typedef struct packed {
		logic no_conv;
		logic few;
		logic found;
		logic not_last;
		logic zero_w;
		logic div_more;
	} cond_flags_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		op_t  op;
		logic busy;
	} ctrl_t;

	// Program step labels.
	localparam logic [PC_BITS-1:0] PC_IDLE = 4'd0;
	localparam logic [PC_BITS-1:0] PC_SCAN = 4'd2;
	localparam logic [PC_BITS-1:0] PC_SEL  = 4'd5;
	localparam logic [PC_BITS-1:0] PC_DIV  = 4'd10;
	localparam logic [PC_BITS-1:0] PC_PASS = 4'd14;
	localparam logic [PC_BITS-1:0] PC_ZW   = 4'd15;

	// The conversion program: a taken condition jumps, otherwise the next step follows.
	function automatic ucode_t ucode_rom(input logic [PC_BITS-1:0] pc);
		ucode_t w;
		case (pc)
			4'd0:    w = '{OP_IDLE,    C_NO_CONV,  PC_IDLE};
			4'd1:    w = '{OP_NOP,     C_FEW,      PC_PASS};
			4'd2:    w = '{OP_RDX,     C_NEVER,    PC_IDLE};
			4'd3:    w = '{OP_NOP,     C_FOUND,    PC_SEL};
			4'd4:    w = '{OP_INCPOS,  C_NOT_LAST, PC_SCAN};
			4'd5:    w = '{OP_SEL,     C_NEVER,    PC_IDLE};
			4'd6:    w = '{OP_RDLO,    C_NEVER,    PC_IDLE};
			4'd7:    w = '{OP_RDHI,    C_NEVER,    PC_IDLE};
			4'd8:    w = '{OP_DIFF,    C_ZW,       PC_ZW};
			4'd9:    w = '{OP_DIVINIT, C_NEVER,    PC_IDLE};
			4'd10:   w = '{OP_DIVSTEP, C_DIV_MORE, PC_DIV};
			4'd11:   w = '{OP_MUL,     C_NEVER,    PC_IDLE};
			4'd12:   w = '{OP_DELTA,   C_NEVER,    PC_IDLE};
			4'd13:   w = '{OP_FINISH,  C_ALWAYS,   PC_IDLE};
			4'd14:   w = '{OP_PASS,    C_ALWAYS,   PC_IDLE};
			4'd15:   w = '{OP_ZW,      C_ALWAYS,   PC_IDLE};
			default: w = '{OP_IDLE,    C_ALWAYS,   PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/plcvt_seq.sv -----
// Microcode sequencer: step counter, control store and conditional jumps.
module plcvt_seq
	import plcvt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cond_flags_t flags,
	output ctrl_t       ctrl
);

	logic [PC_BITS-1:0] pc_q;
	logic [PC_BITS-1:0] pc_d;
	ucode_t             word;
	logic               taken;

	// Fetch the control word and pick the next step.
	always_comb begin
		word = ucode_rom(pc_q);
		case (word.cond)
			C_NEVER:    taken = 1'b0;
			C_ALWAYS:   taken = 1'b1;
			C_NO_CONV:  taken = flags.no_conv;
			C_FEW:      taken = flags.few;
			C_FOUND:    taken = flags.found;
			C_NOT_LAST: taken = flags.not_last;
			C_ZW:       taken = flags.zero_w;
			C_DIV_MORE: taken = flags.div_more;
			default:    taken = 1'b0;
		endcase
		pc_d      = taken ? word.target : pc_q + 1'b1;
		ctrl.op   = word.op;
		ctrl.busy = (pc_q != PC_IDLE);
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

// ----- rtl/piecewise_linear_lut_convert_core.sv -----
// Top level of the piecewise linear lookup converter: breakpoint memory and datapath.
//
// Usage: an item is taken at a rising edge with start high and busy low. A load item
// (kind 0) writes one (x, y) breakpoint in that single beat and gives no result; busy
// stays low. A convert item (kind 1) raises busy until its result is computed; the
// result beat shows on value and status with done high for exactly one cycle, after
// which busy is already low, so the next item may be taken in that same cycle.
// The receiver cannot stall: each result must be taken in its cycle.
// point_count is written through cfg_we / cfg_wdata; the user must write it only while
// the block is idle, as the block itself does not enforce this. With fewer than two
// points a convert passes the sample through. Otherwise the breakpoint scan reads one
// entry at a time over the single read port; a restoring divider then forms the 24-bit
// slope, and one multiply scales the offset by the slope. A zero-width segment skips
// the divide. The microcode sequencer handles one item at a time. Reset clears
// point_count and the control state; breakpoint memory is not cleared and reads of
// unloaded entries are undefined.
`include "piecewise_linear_lut_convert_core_defines.svh"

module piecewise_linear_lut_convert_core
	import plcvt_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   kind,
	input  logic [INDEX_BITS-1:0]  point_index,
	input  logic [FIELD_BITS-1:0]  point_x,
	input  logic [FIELD_BITS-1:0]  point_y,
	input  logic [FIELD_BITS-1:0]  sample,
	input  logic                   cfg_we,
	input  logic [COUNT_BITS-1:0]  cfg_wdata,
	output logic                   done,
	output logic [FIELD_BITS-1:0]  value,
	output logic [STATUS_BITS-1:0] status
);

	localparam int IW = $clog2(MAX_POINTS);
	localparam int PW = $clog2(MAX_POINTS + 1);
	localparam int CW = $clog2(DIV_BITS + 1);
	localparam logic [FIELD_BITS-1:0] MASK16  = FIELD_BITS'(MAX_VALUE64);
	localparam logic [SUM_BITS-1:0]   MAX_SUM = SUM_BITS'(MAX_VALUE64);

	ctrl_t       ctrl;
	cond_flags_t flags;

	logic [COUNT_BITS-1:0] point_count_q;
	logic [FIELD_BITS-1:0] mem_x [MAX_POINTS];
	logic [FIELD_BITS-1:0] mem_y [MAX_POINTS];
	logic [IW-1:0]         rd_addr;
	logic [FIELD_BITS-1:0] rd_x_q, rd_y_q;
	logic                  load_en;

	logic [FIELD_BITS-1:0] sample_q;
	logic [PW-1:0]         n_q, n_d;
	logic [PW-1:0]         pos_q;
	logic [IW-1:0]         lo_q;
	logic                  pos0_q;
	logic [FIELD_BITS-1:0] xl_q, yl_q;
	logic [FIELD_BITS-1:0] dx_q, dy_q, off_q;
	logic                  rising_q;
	logic [FIELD_BITS:0]   rem_q;
	logic [DIV_BITS-1:0]   quo_q;
	logic [CW-1:0]         div_cnt_q;
	logic [PROD_BITS-1:0]  prod_q;
	logic [DELTA_BITS-1:0] delta_q;

	logic [FIELD_BITS:0]   trial;
	logic                  trial_ge;
	logic                  subtract;
	logic [SUM_BITS-1:0]   yl_ext, dl_ext, sum;
	logic [PROD_BITS-1:0]  delta_raw;

	logic                  done_q;
	logic [FIELD_BITS-1:0] value_q;
	status_t               status_q;

	plcvt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	assign busy   = ctrl.busy;
	assign done   = done_q;
	assign value  = value_q;
	assign status = status_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
		end else if (cfg_we) begin
			point_count_q <= cfg_wdata;
		end
	end

	// Breakpoint memory: one write port for loads, one registered read port.
	assign load_en = (ctrl.op == OP_IDLE) && start && !kind
		&& (int'(point_index) < MAX_POINTS);

	always_comb begin
		case (ctrl.op)
			OP_RDLO: rd_addr = lo_q;
			OP_RDHI: rd_addr = IW'(lo_q + 1'b1);
			default: rd_addr = pos_q[IW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			mem_x[IW'(point_index)] <= point_x & MASK16;
			mem_y[IW'(point_index)] <= point_y & MASK16;
		end
		rd_x_q <= mem_x[rd_addr];
		rd_y_q <= mem_y[rd_addr];
	end

	// Effective point count, limited to the table depth.
	assign n_d = (int'(point_count_q) > MAX_POINTS) ? PW'(MAX_POINTS) : PW'(point_count_q);

	// Condition flags for the sequencer.
	always_comb begin
		flags.no_conv  = !(start && kind);
		flags.few      = (n_q < PW'(2));
		flags.found    = (sample_q < rd_x_q);
		flags.not_last = (pos_q != n_q - PW'(1));
		flags.zero_w   = (rd_x_q <= xl_q);
		flags.div_more = (div_cnt_q != CW'(1));
	end

	// Divider step and result arithmetic.
	always_comb begin
		trial     = {rem_q[FIELD_BITS-1:0], quo_q[DIV_BITS-1]};
		trial_ge  = (trial >= {1'b0, dx_q});
		subtract  = pos0_q ? rising_q : !rising_q;
		delta_raw = prod_q >> FRAC_BITS;
		yl_ext    = SUM_BITS'(yl_q);
		dl_ext    = SUM_BITS'(delta_q);
		sum       = yl_ext + dl_ext;
	end

	// Datapath registers, each driven by the operation of the current step.
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_IDLE: begin
				if (start && kind) begin
					sample_q <= sample & MASK16;
					n_q      <= n_d;
					pos_q    <= '0;
				end
			end
			OP_INCPOS: pos_q <= pos_q + 1'b1;
			OP_SEL: begin
				pos0_q <= (pos_q == '0);
				if (pos_q == '0) begin
					lo_q <= '0;
				end else if (pos_q == n_q) begin
					lo_q <= IW'(n_q - PW'(2));
				end else begin
					lo_q <= IW'(pos_q - PW'(1));
				end
			end
			OP_RDHI: begin
				xl_q <= rd_x_q;
				yl_q <= rd_y_q;
			end
			OP_DIFF: begin
				dx_q     <= rd_x_q - xl_q;
				rising_q <= (rd_y_q >= yl_q);
				dy_q     <= (rd_y_q >= yl_q) ? rd_y_q - yl_q : yl_q - rd_y_q;
				off_q    <= pos0_q ? xl_q - sample_q : sample_q - xl_q;
			end
			OP_DIVINIT: begin
				quo_q     <= DIV_BITS'(dy_q) << FRAC_BITS;
				rem_q     <= '0;
				div_cnt_q <= CW'(DIV_BITS);
			end
			OP_DIVSTEP: begin
				rem_q     <= trial_ge ? trial - {1'b0, dx_q} : trial;
				quo_q     <= {quo_q[DIV_BITS-2:0], trial_ge};
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			OP_MUL: prod_q <= PROD_BITS'(off_q) * PROD_BITS'(quo_q);
			OP_DELTA: begin
				if (64'(delta_raw) > MAX_VALUE64) begin
					delta_q <= DELTA_BITS'(MAX_VALUE64 + 64'd1);
				end else begin
					delta_q <= DELTA_BITS'(delta_raw);
				end
			end
			default: begin
			end
		endcase
	end

	// Result beat: value and status held, done pulses for one cycle.
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_PASS: begin
				value_q  <= sample_q;
				status_q <= ST_PASS;
			end
			OP_ZW: begin
				value_q  <= yl_q;
				status_q <= ST_ZERO_WIDTH;
			end
			OP_FINISH: begin
				if (subtract) begin
					if (yl_ext >= dl_ext) begin
						value_q  <= FIELD_BITS'(yl_ext - dl_ext);
						status_q <= ST_OK;
					end else begin
						value_q  <= '0;
						status_q <= ST_CLAMP;
					end
				end else begin
					if (sum > MAX_SUM) begin
						value_q  <= FIELD_BITS'(MAX_SUM);
						status_q <= ST_SAT;
					end else begin
						value_q  <= FIELD_BITS'(sum);
						status_q <= ST_OK;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (ctrl.op == OP_PASS) || (ctrl.op == OP_ZW) || (ctrl.op == OP_FINISH);
		end
	end

	// A result only follows a convert that was in progress.
	`PLCVT_ASSERT_SAME(a_done_after_busy, clk, arst_n, done, $past(busy), "result without a convert in progress")
	// The block is free again in the cycle of the result beat.
	`PLCVT_ASSERT_SAME(a_idle_at_done, clk, arst_n, done, !busy, "busy still high at the result beat")
	// A load completes in its own beat.
	`PLCVT_ASSERT_NEXT(a_load_one_beat, clk, arst_n, start && !busy && !kind, !busy && !done, "load item started a sequence")
	// A convert always starts the sequencer.
	`PLCVT_ASSERT_NEXT(a_conv_starts, clk, arst_n, start && !busy && kind, busy, "convert item did not start the sequencer")

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the piecewise linear lookup converter core.
`timescale 1ns / 1ps

module tb;
	import plcvt_pkg::*;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_CONVERT = 1'b1;
	localparam int   RANDOM_BEATS = 1800;
	localparam int   CYCLE_LIMIT  = 2000000;
	localparam int   PRINT_LIMIT  = 50;

	// One converted result as it leaves the block.
	typedef struct packed {
		logic [FIELD_BITS-1:0] value;
		status_t               status;
	} conv_result_t;

	// One row of the directed stimulus; typed rows carry their own expected result.
	typedef struct packed {
		logic                  set_count;
		logic [COUNT_BITS-1:0] count;
		logic                  knd;
		logic [INDEX_BITS-1:0] idx;
		logic [FIELD_BITS-1:0] x;
		logic [FIELD_BITS-1:0] y;
		logic [FIELD_BITS-1:0] smp;
		logic                  typed;
		logic [FIELD_BITS-1:0] exp_value;
		status_t               exp_status;
	} dir_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   kind = 1'b0;
	logic [INDEX_BITS-1:0]  point_index = '0;
	logic [FIELD_BITS-1:0]  point_x = '0;
	logic [FIELD_BITS-1:0]  point_y = '0;
	logic [FIELD_BITS-1:0]  sample = '0;
	logic                   cfg_we = 1'b0;
	logic [COUNT_BITS-1:0]  cfg_wdata = '0;
	logic                   busy;
	logic                   done;
	logic [FIELD_BITS-1:0]  value;
	logic [STATUS_BITS-1:0] status;

	// Mirror of the breakpoint memory and the point count register.
	logic [FIELD_BITS-1:0]  lut_x [MAX_POINTS_DEF] = '{default: '0};
	logic [FIELD_BITS-1:0]  lut_y [MAX_POINTS_DEF] = '{default: '0};
	bit                     loaded [MAX_POINTS_DEF] = '{default: 1'b0};
	logic [COUNT_BITS-1:0]  lut_count = '0;

	conv_result_t pending_conversions [$];
	int           error_count = 0;
	int           beats_sent = 0;
	int           cycle_count = 0;
	bit           sender_idle_on = 1'b1;

	dir_row_t dir_rows [21];

	piecewise_linear_lut_convert_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.point_index (point_index),
		.point_x     (point_x),
		.point_y     (point_y),
		.sample      (sample),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.value       (value),
		.status      (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("piecewise_linear_lut_convert_core regression: fail");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_LIMIT)
			$display("ERROR at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Expected result of converting one sample through the current table.
	function automatic conv_result_t convert_sample(input logic [FIELD_BITS-1:0] smp);
		conv_result_t          r;
		int                    n;
		int                    pos;
		int                    lo;
		logic [FIELD_BITS-1:0] xl, xh, yl, yh, dx, dy, off;
		logic [23:0]           slope;
		logic [39:0]           prod;
		logic [31:0]           delta;
		logic [16:0]           sum;
		bit                    rising, subtract;
		n = (lut_count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(lut_count);
		r.status = ST_OK;
		if (n < 2) begin
			r.value = smp;
			r.status = ST_PASS;
			return r;
		end
		pos = 0;
		while (pos < n && !(smp < lut_x[pos]))
			pos++;
		if (pos == 0)
			lo = 0;
		else if (pos >= n)
			lo = n - 2;
		else
			lo = pos - 1;
		xl = lut_x[lo];
		xh = lut_x[lo+1];
		yl = lut_y[lo];
		yh = lut_y[lo+1];
		// A segment that does not move forward in x yields its low point.
		if (xh <= xl) begin
			r.value = yl;
			r.status = ST_ZERO_WIDTH;
			return r;
		end
		dx = xh - xl;
		rising = (yh >= yl);
		dy = rising ? yh - yl : yl - yh;
		slope = {dy, 8'd0} / {8'd0, dx};
		off = (pos == 0) ? xl - smp : smp - xl;
		prod = off * slope;
		delta = prod[39:FRAC_BITS];
		if (delta > 32'd65535)
			delta = 32'd65536;
		// Below the table the first segment is walked backwards.
		subtract = (pos == 0) ? rising : !rising;
		if (subtract) begin
			if (yl >= delta) begin
				r.value = yl - delta[FIELD_BITS-1:0];
			end else begin
				r.value = '0;
				r.status = ST_CLAMP;
			end
		end else begin
			sum = yl + delta[16:0];
			if (sum > 17'd65535) begin
				r.value = 16'hFFFF;
				r.status = ST_SAT;
			end else begin
				r.value = sum[FIELD_BITS-1:0];
			end
		end
		return r;
	endfunction

	// Present one beat, hold it until the block takes it, then update the mirror.
	task automatic send_item(input logic knd, input logic [INDEX_BITS-1:0] idx,
			input logic [FIELD_BITS-1:0] x, input logic [FIELD_BITS-1:0] y,
			input logic [FIELD_BITS-1:0] smp, input logic typed,
			input logic [FIELD_BITS-1:0] exp_value, input status_t exp_status);
		int           gap;
		conv_result_t r;
		gap = sender_idle_on ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= knd;
		point_index <= idx;
		point_x <= x;
		point_y <= y;
		sample <= smp;
		do
			@(posedge clk);
		while (busy);
		beats_sent++;
		if (knd == KIND_LOAD) begin
			lut_x[idx] = x;
			lut_y[idx] = y;
			loaded[idx] = 1'b1;
		end else begin
			if (typed) begin
				r.value = exp_value;
				r.status = exp_status;
			end else begin
				r = convert_sample(smp);
			end
			pending_conversions.push_back(r);
		end
	endtask

	// Stop sending and wait until every conversion has reported back.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_conversions.size() != 0 || busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_point_count(input logic [COUNT_BITS-1:0] cnt);
		cfg_we <= 1'b1;
		cfg_wdata <= cnt;
		@(posedge clk);
		cfg_we <= 1'b0;
		lut_count = cnt;
	endtask

	// Load entries 0..n-1 with non-decreasing x and a random shape in y.
	task automatic load_ramp(input int n);
		int x, y, step_max, y_mode, k;
		case ($urandom_range(0, 3))
			0: step_max = 8;
			1: step_max = 300;
			2: step_max = 4000;
			default: step_max = 65535 / n;
		endcase
		y_mode = $urandom_range(0, 2);
		x = $urandom_range(0, step_max * 2);
		y = $urandom_range(0, 65535);
		for (k = 0; k < n; k++) begin
			if (k > 0 && $urandom_range(0, 9) != 0)
				x += $urandom_range(1, step_max);
			if (x > 65535)
				x = 65535;
			case (y_mode)
				0: y = $urandom_range(0, 65535);
				1: y = y + $urandom_range(0, 4000) - 2000;
				default: y = $urandom_range(0, 1) ? 65535 : $urandom_range(0, 15);
			endcase
			if (y < 0)
				y = 0;
			if (y > 65535)
				y = 65535;
			send_item(KIND_LOAD, k[INDEX_BITS-1:0], x[FIELD_BITS-1:0], y[FIELD_BITS-1:0],
				FIELD_BITS'($urandom), 1'b0, '0, ST_OK);
		end
	endtask

	// One random phase: a count setting, a table when there are two points or more, then mostly conversions.
	task automatic run_random_phase();
		logic [COUNT_BITS-1:0] cnt;
		int                    n, m, r, k, s;
		case ($urandom_range(0, 11))
			0: cnt = COUNT_BITS'($urandom_range(0, 1));
			1, 2: cnt = COUNT_BITS'(MAX_POINTS_DEF);
			3: cnt = COUNT_BITS'($urandom_range(17, 31));
			4: cnt = COUNT_BITS'(2);
			default: cnt = COUNT_BITS'($urandom_range(3, 15));
		endcase
		n = (cnt > MAX_POINTS_DEF) ? MAX_POINTS_DEF : int'(cnt);
		drain_results();
		write_point_count(cnt);
		sender_idle_on = ($urandom_range(0, 3) != 0);
		if (n >= 2) begin
			if ($urandom_range(0, 4) != 0) begin
				load_ramp(n);
			end else begin
				// Keep the old table and fill only entries never loaded.
				for (k = 0; k < n; k++)
					if (!loaded[k])
						send_item(KIND_LOAD, k[INDEX_BITS-1:0], FIELD_BITS'($urandom),
							FIELD_BITS'($urandom), FIELD_BITS'($urandom), 1'b0, '0,
							ST_OK);
			end
		end
		m = $urandom_range(10, 60);
		repeat (m) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				send_item(KIND_LOAD, INDEX_BITS'($urandom), FIELD_BITS'($urandom),
					FIELD_BITS'($urandom), FIELD_BITS'($urandom), 1'b0, '0, ST_OK);
			end else if (r < 15) begin
				drain_results();
			end else begin
				case ($urandom_range(0, 5))
					0, 1: begin
						k = $urandom_range(0, (n >= 2) ? n - 1 : MAX_POINTS_DEF - 1);
						s = int'(lut_x[k]) + $urandom_range(0, 4) - 2;
						if (s < 0)
							s = 0;
						if (s > 65535)
							s = 65535;
					end
					2: s = $urandom_range(0, 1) ? 65535 : 0;
					3: s = (n >= 2) ? $urandom_range(lut_x[0], lut_x[n-1]) : $urandom_range(0, 65535);
					default: s = $urandom_range(0, 65535);
				endcase
				send_item(KIND_CONVERT, INDEX_BITS'($urandom), FIELD_BITS'($urandom),
					FIELD_BITS'($urandom), s[FIELD_BITS-1:0], 1'b0, '0, ST_OK);
			end
		end
	endtask

	// Result beats are compared with the oldest outstanding conversion.
	always @(posedge clk) begin
		conv_result_t want;
		if (arst_n && done) begin
			if (pending_conversions.size() == 0) begin
				report_mismatch($sformatf("unexpected result beat value=%0d status=%0d",
					value, status));
			end else begin
				want = pending_conversions.pop_front();
				if (value !== want.value)
					report_mismatch($sformatf("value %0d, expected %0d", value, want.value));
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d", status,
						want.status));
			end
		end
	end

	initial begin
		// Directed rows: pass-through with no points, a table of four points, then extremes and each special case.
		dir_rows = '{
			'{1'b1, 5'd0, KIND_CONVERT, 4'd0, 16'd0, 16'd0, 16'd0, 1'b1, 16'd0, ST_PASS},
			'{1'b0, 5'd0, KIND_CONVERT, 4'd0, 16'd0, 16'd0, 16'hFFFF, 1'b1, 16'hFFFF, ST_PASS},
			'{1'b0, 5'd0, KIND_LOAD, 4'd0, 16'd100, 16'd1000, 16'hFFFF, 1'b0, 16'd0, ST_OK},
			'{1'b0, 5'd0, KIND_LOAD, 4'd1, 16'd200, 16'd3000, 16'd0, 1'b0, 16'd0, ST_OK},
			'{1'b0, 5'd0, KIND_LOAD, 4'd2, 16'd300, 16'd2000, 16'd0, 1'b0, 16'd0, ST_OK},
			'{1'b0, 5'd0, KIND_LOAD, 4'd3, 16'd300, 16'd500, 16'd0, 1'b0, 16'd0, ST_OK},
			'{1'b1, 5'd1, KIND_CONVERT, 4'd0, 16'd0, 16'd0, 16'd150, 1'b1, 16'd150, ST_PASS},
			'{1'b1, 5'd4, KIND_CONVERT, 4'hF, 16'hFFFF, 16'hFFFF, 16'd50, 1'b1, 16'd0, ST_OK},
			'{1'b0, 5'd0, KIND_CONVERT, 4'd0, 16'd0, 16'd0, 16'd0, 1'b1, 16'd0, ST_CLAMP},
			'{1'b0, 5'd0, KIND_CONVERT, 4'd0, 16'd0, 16'd0, 16'd150, 1'b0, 16'd0, ST_OK},
			'{1'b0, 5'd0, KIND_CONVERT, 4'd0, 16'd0, 16'd0, 16'd250, 1'b0, 16'd0, ST_OK},
			'{1'b0, 5'd0, KIND_CONVERT, 4'd0, 16'd0, 16'd0, 16'd300, 1'b1, 16'd2000,
				ST_ZERO_WIDTH},
			'{1'b0, 5'd0, KIND_CONVERT, 4'd0, 16'd0, 16'd0, 16'hFFFF, 1'b0, 16'd0, ST_OK},
			'{1'b0, 5'd0, KIND_LOAD, 4'd3, 16'd400, 16'd65000, 16'd0, 1'b0, 16'd0, ST_OK},
			'{1'b0, 5'd0, KIND_CONVERT, 4'd0, 16'd0, 16'd0, 16'hFFFF, 1'b1, 16'hFFFF, ST_SAT},
			'{1'b0, 5'd0, KIND_LOAD, 4'hF, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0, 16'd0, ST_OK},
			'{1'b0, 5'd0, KIND_LOAD, 4'hE, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0, ST_OK},
			'{1'b0, 5'd0, KIND_CONVERT, 4'd0, 16'd0, 16'd0, 16'd200, 1'b0, 16'd0, ST_OK},
			'{1'b0, 5'd0, KIND_LOAD, 4'd0, 16'd100, 16'd65000, 16'd0, 1'b0, 16'd0, ST_OK},
			'{1'b0, 5'd0, KIND_CONVERT, 4'd0, 16'd0, 16'd0, 16'd0, 1'b1, 16'hFFFF, ST_SAT},
			'{1'b0, 5'd0, KIND_CONVERT, 4'd0, 16'd0, 16'd0, 16'd99, 1'b0, 16'd0, ST_OK}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].set_count) begin
				drain_results();
				write_point_count(dir_rows[i].count);
			end
			send_item(dir_rows[i].knd, dir_rows[i].idx, dir_rows[i].x, dir_rows[i].y,
				dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].exp_value,
				dir_rows[i].exp_status);
		end

		while (beats_sent < RANDOM_BEATS + $size(dir_rows))
			run_random_phase();

		drain_results();
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("piecewise_linear_lut_convert_core regression: pass");
		else
			$display("piecewise_linear_lut_convert_core regression: fail");
		$finish;
	end

endmodule
